// ===== src/wdce_pkg.sv =====
// Package for the WAV data chunk extractor.
// Holds the item types, parse phase codes and tag constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wdce_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_of_file;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_payload;
        logic       status;
    } t_out_item;

    localparam int PHASE_W = 4;
    localparam int POS_W   = 11;
    localparam int LIMIT_W = 10;

    localparam logic [PHASE_W-1:0] PH_RIFF     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RIFFSIZE = 4'd1;
    localparam logic [PHASE_W-1:0] PH_WAVE     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_ID       = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SIZE     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SKIP     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_PAD      = 4'd6;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_DONE     = 4'd8;
    localparam logic [PHASE_W-1:0] PH_ERROR    = 4'd9;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RESET = 10'd1000;
    localparam logic [POS_W-1:0]   POS_MAX          = 11'd2047;

    localparam logic STATUS_PAYLOAD = 1'b0;
    localparam logic STATUS_ERROR   = 1'b1;

endpackage

`default_nettype wire

// ===== src/wdce_out_reg.sv =====
// Result register for the WAV data chunk extractor.
// Holds one result word until the consumer takes it; uses wdce_pkg types.
`timescale 1ns / 1ps
`default_nettype none

module wdce_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire wdce_pkg::t_out_item i_item,
    input  wire logic               i_out_stall,
    output logic                    o_free,
    output logic                    o_out_valid,
    output wdce_pkg::t_out_item     o_out_data
);

    logic                r_valid;
    logic                n_valid;
    wdce_pkg::t_out_item r_item;

    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload needs no reset; load only when the slot frees up
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_item <= i_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_item;

endmodule

`default_nettype wire

// ===== src/wdce_parser.sv =====
// RIFF/WAVE parse engine: phase, position, tag shift and byte counters.
// Consumes one registered byte per fire strobe; uses wdce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wdce_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire wdce_pkg::t_in_item            i_item,
    input  wire logic [wdce_pkg::LIMIT_W-1:0]  i_scan_limit,
    output logic                               o_res_valid,
    output wdce_pkg::t_out_item                o_res
);

    logic [wdce_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [wdce_pkg::POS_W-1:0]   r_pos,   n_pos;
    logic [1:0]                   r_bif,   n_bif;
    logic [31:0]                  r_shift, n_shift;
    logic [31:0]                  r_rem,   n_rem;
    logic                         r_mis,   n_mis;

    // state seen by this byte, after an optional restart
    logic [wdce_pkg::PHASE_W-1:0] c_phase;
    logic [wdce_pkg::POS_W-1:0]   c_pos;
    logic [1:0]                   c_bif;
    logic [31:0]                  c_shift;
    logic [31:0]                  c_rem;
    logic                         c_mis;
    logic [31:0]                  shifted;
    logic [1:0]                   bif_inc;
    logic [31:0]                  rem_dec;
    logic                         id_mis;
    logic                         past_limit;

    always_comb begin
        if (i_item.start_of_file) begin
            c_phase = wdce_pkg::PH_RIFF;
            c_pos   = '0;
            c_bif   = '0;
            c_shift = '0;
            c_rem   = '0;
            c_mis   = 1'b0;
        end else begin
            c_phase = r_phase;
            c_pos   = r_pos;
            c_bif   = r_bif;
            c_shift = r_shift;
            c_rem   = r_rem;
            c_mis   = r_mis;
        end
    end

    assign shifted    = {i_item.in_byte, c_shift[31:8]};
    assign bif_inc    = c_bif + 2'd1;
    assign rem_dec    = c_rem - 32'd1;
    assign id_mis     = (shifted != wdce_pkg::TAG_DATA);
    // chunk header starts three bytes before this one
    assign past_limit = ({1'b0, c_pos} >= ({2'b00, i_scan_limit} + 12'd3));

    always_comb begin
        n_phase     = c_phase;
        n_pos       = (c_pos < wdce_pkg::POS_MAX) ? c_pos + 11'd1 : c_pos;
        n_bif       = c_bif;
        n_shift     = c_shift;
        n_rem       = c_rem;
        n_mis       = c_mis;
        o_res_valid = 1'b0;
        o_res       = '{out_byte: 8'd0, last_payload: 1'b0,
                        status: wdce_pkg::STATUS_ERROR};

        unique case (c_phase)
            wdce_pkg::PH_RIFF, wdce_pkg::PH_RIFFSIZE, wdce_pkg::PH_WAVE,
            wdce_pkg::PH_ID, wdce_pkg::PH_SIZE: begin
                n_shift = shifted;
                n_bif   = bif_inc;
                if (bif_inc == 2'd0) begin
                    unique case (c_phase)
                        wdce_pkg::PH_RIFF: begin
                            if (shifted != wdce_pkg::TAG_RIFF) begin
                                n_phase     = wdce_pkg::PH_ERROR;
                                o_res_valid = 1'b1;
                            end else begin
                                n_phase = wdce_pkg::PH_RIFFSIZE;
                            end
                        end
                        wdce_pkg::PH_RIFFSIZE: begin
                            n_phase = wdce_pkg::PH_WAVE;
                        end
                        wdce_pkg::PH_WAVE: begin
                            if (shifted != wdce_pkg::TAG_WAVE) begin
                                n_phase     = wdce_pkg::PH_ERROR;
                                o_res_valid = 1'b1;
                            end else begin
                                n_phase = wdce_pkg::PH_ID;
                            end
                        end
                        wdce_pkg::PH_ID: begin
                            n_mis = id_mis;
                            if (id_mis && past_limit) begin
                                n_phase     = wdce_pkg::PH_ERROR;
                                o_res_valid = 1'b1;
                            end else begin
                                n_phase = wdce_pkg::PH_SIZE;
                            end
                        end
                        default: begin
                            // size field complete: little-endian count
                            n_rem = shifted;
                            if (!c_mis) begin
                                n_phase = (shifted == 32'd0) ? wdce_pkg::PH_DONE
                                                             : wdce_pkg::PH_PAYLOAD;
                            end else if (shifted != 32'd0) begin
                                n_bif   = {1'b0, shifted[0]};
                                n_phase = wdce_pkg::PH_SKIP;
                            end else begin
                                n_phase = wdce_pkg::PH_ID;
                            end
                        end
                    endcase
                end
            end
            wdce_pkg::PH_SKIP: begin
                n_rem = rem_dec;
                if (rem_dec == 32'd0) begin
                    // odd size leaves one pad byte to drop
                    n_phase = c_bif[0] ? wdce_pkg::PH_PAD : wdce_pkg::PH_ID;
                    n_bif   = 2'd0;
                end
            end
            wdce_pkg::PH_PAD: begin
                n_phase = wdce_pkg::PH_ID;
                n_bif   = 2'd0;
            end
            wdce_pkg::PH_PAYLOAD: begin
                n_rem       = rem_dec;
                o_res_valid = 1'b1;
                o_res       = '{out_byte: i_item.in_byte,
                                last_payload: (rem_dec == 32'd0),
                                status: wdce_pkg::STATUS_PAYLOAD};
                if (rem_dec == 32'd0) begin
                    n_phase = wdce_pkg::PH_DONE;
                end
            end
            default: begin
                // done, error: drop bytes until the next start of file
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wdce_pkg::PH_RIFF;
            r_pos   <= '0;
            r_bif   <= '0;
            r_shift <= '0;
            r_rem   <= '0;
            r_mis   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_bif   <= n_bif;
            r_shift <= n_shift;
            r_rem   <= n_rem;
            r_mis   <= n_mis;
        end
    end

    a_err_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res_valid && o_res.status == wdce_pkg::STATUS_ERROR)
        |=> (r_phase == wdce_pkg::PH_ERROR))
        else $error("error result did not park the parser");

    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wdce_pkg::PH_PAYLOAD || r_phase == wdce_pkg::PH_SKIP)
        |-> (r_rem != 32'd0))
        else $error("byte count exhausted while still counting");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res_valid && o_res.last_payload)
        |=> (r_phase == wdce_pkg::PH_DONE))
        else $error("last payload byte did not finish the chunk");

endmodule

`default_nettype wire

// ===== src/wav_data_chunk_extractor.sv =====
// Top level of the WAV data chunk extractor: input register, config register,
// parse engine and result register. Uses wdce_pkg, wdce_parser, wdce_out_reg.
//
// Takes one WAV file byte per cycle with no gaps of its own: a byte entering the
// input register is parsed there and its result (a data chunk byte, or one
// error word) is loaded into the result register once that register is free.
// The per-byte phase update and the 32-bit count decrement lie on the path
// from the input register to the result register. Header bytes and skipped
// chunks give no result word. The input stalls only when the result register
// is full and the consumer stalls.
`timescale 1ns / 1ps
`default_nettype none

module wav_data_chunk_extractor (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire wdce_pkg::t_in_item            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output wdce_pkg::t_out_item                o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [wdce_pkg::LIMIT_W-1:0]  i_cfg_data
);

    logic                         r_in_valid;
    logic                         n_in_valid;
    wdce_pkg::t_in_item           r_in;
    logic [wdce_pkg::LIMIT_W-1:0] r_scan_limit;
    logic                         out_free;
    logic                         advance;
    logic                         accept;
    logic                         res_valid;
    wdce_pkg::t_out_item          res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_limit <= wdce_pkg::SCAN_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_scan_limit <= i_cfg_data;
        end
    end

    // advance the held word whenever the result slot can take its outcome
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    wdce_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_item       (r_in),
        .i_scan_limit (r_scan_limit),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    wdce_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && res_valid),
        .i_item      (res),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
